>>> rtl/core/pfgp_pkg.sv
// ----------------------------------------------------------------------------
// pfgp_pkg: shared types and constants of the page framebuffer glyph plotter
// Command and response items, op codes, status codes, register indexes.
// ----------------------------------------------------------------------------
package pfgp_pkg;

	localparam int FW_W       = 5;
	localparam int FH_W       = 6;
	localparam int CFG_IDX_W  = 2;
	localparam int CFG_DATA_W = 6;
	localparam int LANES      = 2 ** FW_W;
	localparam int LANE_IDX_W = FW_W;

	localparam logic [CFG_IDX_W-1:0] CFG_FONT_WIDTH  = 2'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_FONT_HEIGHT = 2'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_INVERT      = 2'd2;

	localparam logic [FW_W-1:0] FONT_WIDTH_RST  = 5'd7;
	localparam logic [FH_W-1:0] FONT_HEIGHT_RST = 6'd10;

	localparam logic [1:0] STAT_DONE    = 2'd0;
	localparam logic [1:0] STAT_CTRL    = 2'd1;
	localparam logic [1:0] STAT_NO_ROOM = 2'd2;
	localparam logic [1:0] STAT_OUTSIDE = 2'd3;

	localparam logic [15:0] PIXEL_BITS      = 16'h8000;
	localparam logic [6:0]  FIRST_PRINTABLE = 7'd32;

	typedef enum logic [2:0] {
		OP_PIXEL  = 3'd0,
		OP_FILL   = 3'd1,
		OP_CURSOR = 3'd2,
		OP_CHAR   = 3'd3,
		OP_ROW    = 3'd4,
		OP_READ   = 3'd5
	} op_t;

	typedef struct packed {
		logic [2:0]  op;
		logic [7:0]  x_pos;
		logic [7:0]  y_pos;
		logic        color;
		logic [6:0]  char_code;
		logic [5:0]  row_index;
		logic [15:0] row_bits;
		logic        last_row;
		logic [9:0]  byte_address;
	} cmd_t;

	typedef struct packed {
		logic [1:0] status;
		logic [7:0] read_byte;
	} rsp_t;

endpackage

>>> rtl/core/pfgp_if.sv
// ----------------------------------------------------------------------------
// pfgp_if: valid/ready channels of the plotter
// Command channel and response channel, each with source and sink modports.
// ----------------------------------------------------------------------------
interface pfgp_cmd_if;
	logic            valid;
	logic            ready;
	pfgp_pkg::cmd_t  payload;

	modport source (output valid, output payload, input ready);
	modport sink   (input valid, input payload, output ready);
endinterface

interface pfgp_rsp_if;
	logic            valid;
	logic            ready;
	pfgp_pkg::rsp_t  payload;

	modport source (output valid, output payload, input ready);
	modport sink   (input valid, input payload, output ready);
endinterface

>>> rtl/core/pfgp_ram.sv
// ----------------------------------------------------------------------------
// pfgp_ram: generic simple dual-port RAM
// One write port, one read port with registered read data.
// ----------------------------------------------------------------------------
module pfgp_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 640
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

>>> rtl/core/pfgp_lane.sv
// ----------------------------------------------------------------------------
// pfgp_lane: one glyph column lane
// Works out whether its column is drawn, its byte address and its pixel value.
// ----------------------------------------------------------------------------
module pfgp_lane #(
	parameter int SCREEN_WIDTH  = 128,
	parameter int SCREEN_HEIGHT = 40,
	parameter int LANE          = 0,
	parameter int ADDR_W        = 10
) (
	input  logic [7:0]                      base_x,
	input  logic [8:0]                      base_y,
	input  logic [ADDR_W-1:0]               page_base,
	input  logic [pfgp_pkg::LANE_IDX_W-1:0] cnt,
	input  logic [15:0]                     bits,
	input  logic                            color,
	input  logic                            invert,
	output logic                            wr,
	output logic [ADDR_W-1:0]               addr,
	output logic                            val
);
	import pfgp_pkg::*;

	logic [8:0] x;
	logic       fg;

	assign x = 9'(base_x) + 9'(LANE);

	// columns past the glyph word are background
	generate
		if (LANE < 16) begin : g_bit
			assign fg = bits[15-LANE];
		end else begin : g_bg
			assign fg = 1'b0;
		end
	endgenerate

	assign wr   = (LANE_IDX_W'(LANE) < cnt) && (x < 9'(SCREEN_WIDTH))
		&& (base_y < 9'(SCREEN_HEIGHT));
	assign addr = page_base + ADDR_W'(x);
	assign val  = (fg ? color : ~color) ^ invert;

endmodule

>>> rtl/core/page_framebuffer_glyph_plotter.sv
// ----------------------------------------------------------------------------
// page_framebuffer_glyph_plotter: monochrome page framebuffer with text plotter
// Pixel plot, fill, cursor, character start, glyph rows and byte read-back.
// ----------------------------------------------------------------------------
// Usage:
//   cmd carries one op item per handshake; rsp returns exactly one item
//   (status, read_byte) per command, in order. Registers are written through
//   cfg_we/cfg_index/cfg_data; write them only while the block is idle, as the
//   block itself does not enforce this. One command is worked on at a time;
//   cmd.ready is high only when idle.
//   Glyph rows are set by the read-modify-write walk over the column lanes,
//   one buffer byte per cycle through the RAM ports; fill by one byte a cycle.
//   After reset the buffer is cleared, all SCREEN_WIDTH * ceil(SCREEN_HEIGHT/8)
//   bytes (640 by default), before the first command is taken.
//   A response waits in an output register while rsp.ready is low; the next
//   command is still accepted, and its response waits for that register.
// ----------------------------------------------------------------------------
module page_framebuffer_glyph_plotter #(
	parameter int SCREEN_WIDTH  = 128,
	parameter int SCREEN_HEIGHT = 40
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            cfg_we,
	input  logic [pfgp_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [pfgp_pkg::CFG_DATA_W-1:0] cfg_data,
	pfgp_cmd_if.sink                        cmd,
	pfgp_rsp_if.source                      rsp
);
	import pfgp_pkg::*;

	localparam int PAGES    = (SCREEN_HEIGHT + 7) / 8;
	localparam int FB_BYTES = SCREEN_WIDTH * PAGES;
	localparam int ADDR_W   = $clog2(FB_BYTES);

	typedef enum logic [2:0] {
		S_CLEAR, S_IDLE, S_LANE, S_WALK, S_DRAIN, S_RDREQ, S_RDDATA, S_RESP
	} state_t;

	state_t              state_q;
	logic [ADDR_W-1:0]   sweep_q;
	logic [7:0]          fill_val_q;
	logic                resp_pend_q;
	logic [FW_W-1:0]     font_width_q;
	logic [FH_W-1:0]     font_height_q;
	logic                invert_q;
	logic [7:0]          cursor_x_q;
	logic [7:0]          cursor_y_q;
	logic                char_acc_q;
	logic                out_valid_q;
	rsp_t                out_q;
	logic [1:0]          status_q;
	logic [7:0]          rd_q;
	logic [LANE_IDX_W-1:0] k_q;
	logic                pend_s3;
	logic [ADDR_W-1:0]   pend_addr_s3;
	logic                pend_val_s3;

	logic [7:0]            base_x_s1;
	logic [8:0]            base_y_s1;
	logic [LANE_IDX_W-1:0] cnt_s1;
	logic [15:0]           bits_s1;
	logic                  color_s1;
	logic [9:0]            byte_addr_q;

	logic                lane_wr [LANES];
	logic [ADDR_W-1:0]   lane_addr [LANES];
	logic                lane_val [LANES];
	logic                lane_wr_s2 [LANES];
	logic [ADDR_W-1:0]   lane_addr_s2 [LANES];
	logic                lane_val_s2 [LANES];

	logic                in_acc;
	logic [ADDR_W-1:0]   page_base;
	logic [7:0]          bit_mask;
	logic                ram_we;
	logic [ADDR_W-1:0]   ram_waddr;
	logic [7:0]          ram_wdata;
	logic [ADDR_W-1:0]   ram_raddr;
	logic [7:0]          ram_rdata;
	logic                pix_out;
	logic                no_room;
	logic                rd_ok;

	assign cmd.ready   = (state_q == S_IDLE);
	assign in_acc      = cmd.valid && cmd.ready;
	assign rsp.valid   = out_valid_q;
	assign rsp.payload = out_q;

	assign pix_out = (9'(cmd.payload.x_pos) >= 9'(SCREEN_WIDTH))
		|| (9'(cmd.payload.y_pos) >= 9'(SCREEN_HEIGHT));
	assign no_room = (9'(cursor_x_q) + 9'(font_width_q) >= 9'(SCREEN_WIDTH))
		|| (9'(cursor_y_q) + 9'(font_height_q) >= 9'(SCREEN_HEIGHT));
	assign rd_ok   = 12'(cmd.payload.byte_address) < 12'(FB_BYTES);

	// column lanes
	assign page_base = ADDR_W'(32'(base_y_s1[5:3]) * SCREEN_WIDTH);

	generate
		for (genvar j = 0; j < LANES; j++) begin : g_lane
			pfgp_lane #(
				.SCREEN_WIDTH (SCREEN_WIDTH),
				.SCREEN_HEIGHT(SCREEN_HEIGHT),
				.LANE         (j),
				.ADDR_W       (ADDR_W)
			) u_lane (
				.base_x   (base_x_s1),
				.base_y   (base_y_s1),
				.page_base(page_base),
				.cnt      (cnt_s1),
				.bits     (bits_s1),
				.color    (color_s1),
				.invert   (invert_q),
				.wr       (lane_wr[j]),
				.addr     (lane_addr[j]),
				.val      (lane_val[j])
			);

			always_ff @(posedge clk) begin
				if (state_q == S_LANE) begin
					lane_wr_s2[j]   <= lane_wr[j];
					lane_addr_s2[j] <= lane_addr[j];
					lane_val_s2[j]  <= lane_val[j];
				end
			end
		end
	endgenerate

	// buffer read-modify-write
	assign bit_mask = 8'b1 << base_y_s1[2:0];

	always_comb begin
		ram_raddr = (state_q == S_WALK) ? lane_addr_s2[k_q] : ADDR_W'(byte_addr_q);
		if (state_q == S_CLEAR) begin
			ram_we    = 1'b1;
			ram_waddr = sweep_q;
			ram_wdata = fill_val_q;
		end else begin
			ram_we    = pend_s3;
			ram_waddr = pend_addr_s3;
			ram_wdata = pend_val_s3 ? (ram_rdata | bit_mask) : (ram_rdata & ~bit_mask);
		end
	end

	pfgp_ram #(
		.WIDTH(8),
		.DEPTH(FB_BYTES)
	) u_ram (
		.clk  (clk),
		.we   (ram_we),
		.waddr(ram_waddr),
		.wdata(ram_wdata),
		.raddr(ram_raddr),
		.rdata(ram_rdata)
	);

	// item capture
	always_ff @(posedge clk) begin
		if (in_acc) begin
			color_s1    <= cmd.payload.color;
			byte_addr_q <= cmd.payload.byte_address;
			if (op_t'(cmd.payload.op) == OP_PIXEL) begin
				base_x_s1 <= cmd.payload.x_pos;
				base_y_s1 <= 9'(cmd.payload.y_pos);
				cnt_s1    <= LANE_IDX_W'(1);
				bits_s1   <= PIXEL_BITS;
			end else begin
				base_x_s1 <= cursor_x_q;
				base_y_s1 <= 9'(cursor_y_q) + 9'(cmd.payload.row_index);
				cnt_s1    <= font_width_q;
				bits_s1   <= cmd.payload.row_bits;
			end
		end
		if (state_q == S_WALK) begin
			pend_addr_s3 <= lane_addr_s2[k_q];
			pend_val_s3  <= lane_val_s2[k_q];
		end
	end

	// control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q       <= S_CLEAR;
			sweep_q       <= '0;
			fill_val_q    <= '0;
			resp_pend_q   <= 1'b0;
			font_width_q  <= FONT_WIDTH_RST;
			font_height_q <= FONT_HEIGHT_RST;
			invert_q      <= 1'b0;
			cursor_x_q    <= '0;
			cursor_y_q    <= '0;
			char_acc_q    <= 1'b0;
			out_valid_q   <= 1'b0;
			out_q         <= '0;
			status_q      <= STAT_DONE;
			rd_q          <= '0;
			k_q           <= '0;
			pend_s3       <= 1'b0;
		end else begin
			if (cfg_we) begin
				unique case (cfg_index)
					CFG_FONT_WIDTH:  font_width_q  <= cfg_data[FW_W-1:0];
					CFG_FONT_HEIGHT: font_height_q <= cfg_data[FH_W-1:0];
					CFG_INVERT:      invert_q      <= cfg_data[0];
					default: ;
				endcase
			end

			if (rsp.ready && state_q != S_RESP) begin
				out_valid_q <= 1'b0;
			end
			pend_s3 <= (state_q == S_WALK) && lane_wr_s2[k_q];

			unique case (state_q)
				S_CLEAR: begin
					if (sweep_q == ADDR_W'(FB_BYTES - 1)) begin
						sweep_q     <= '0;
						resp_pend_q <= 1'b0;
						state_q     <= resp_pend_q ? S_RESP : S_IDLE;
					end else begin
						sweep_q <= sweep_q + 1'b1;
					end
				end
				S_IDLE: begin
					if (cmd.valid) begin
						rd_q <= '0;
						unique case (op_t'(cmd.payload.op))
							OP_PIXEL: begin
								status_q <= pix_out ? STAT_OUTSIDE : STAT_DONE;
								state_q  <= S_LANE;
							end
							OP_FILL: begin
								status_q    <= STAT_DONE;
								fill_val_q  <= {8{cmd.payload.color}};
								sweep_q     <= '0;
								resp_pend_q <= 1'b1;
								state_q     <= S_CLEAR;
							end
							OP_CURSOR: begin
								status_q   <= STAT_DONE;
								cursor_x_q <= cmd.payload.x_pos;
								cursor_y_q <= cmd.payload.y_pos;
								state_q    <= S_RESP;
							end
							OP_CHAR: begin
								if (cmd.payload.char_code < FIRST_PRINTABLE) begin
									char_acc_q <= 1'b0;
									status_q   <= STAT_CTRL;
								end else if (no_room) begin
									char_acc_q <= 1'b0;
									status_q   <= STAT_NO_ROOM;
								end else begin
									char_acc_q <= 1'b1;
									status_q   <= STAT_DONE;
								end
								state_q <= S_RESP;
							end
							OP_ROW: begin
								if (!char_acc_q) begin
									status_q <= STAT_NO_ROOM;
									state_q  <= S_RESP;
								end else begin
									if (cmd.payload.row_index < font_height_q) begin
										status_q <= STAT_DONE;
										state_q  <= S_LANE;
									end else begin
										status_q <= STAT_OUTSIDE;
										state_q  <= S_RESP;
									end
									if (cmd.payload.last_row) begin
										cursor_x_q <= cursor_x_q + 8'(font_width_q);
										char_acc_q <= 1'b0;
									end
								end
							end
							OP_READ: begin
								if (rd_ok) begin
									status_q <= STAT_DONE;
									state_q  <= S_RDREQ;
								end else begin
									status_q <= STAT_OUTSIDE;
									state_q  <= S_RESP;
								end
							end
							default: begin
								status_q <= STAT_DONE;
								state_q  <= S_RESP;
							end
						endcase
					end
				end
				S_LANE: begin
					k_q     <= '0;
					state_q <= (cnt_s1 == '0) ? S_RESP : S_WALK;
				end
				S_WALK: begin
					k_q <= k_q + 1'b1;
					if (k_q == cnt_s1 - 1'b1) begin
						state_q <= S_DRAIN;
					end
				end
				S_DRAIN: state_q <= S_RESP;
				S_RDREQ: state_q <= S_RDDATA;
				S_RDDATA: begin
					rd_q    <= ram_rdata;
					state_q <= S_RESP;
				end
				S_RESP: begin
					if (!out_valid_q || rsp.ready) begin
						out_valid_q       <= 1'b1;
						out_q.status      <= status_q;
						out_q.read_byte   <= rd_q;
						state_q           <= S_IDLE;
					end
				end
			endcase
		end
	end

endmodule

>>> bench/page_framebuffer_glyph_plotter_test.sv
// ----------------------------------------------------------------------------
// page_framebuffer_glyph_plotter_test: self-checking bench of the glyph plotter
// Drives command items with random gaps, stalls the response side at random and
// compares every response item against a software image of the framebuffer,
// cursor and character state. Directed cases first, then text drawing under
// several font settings mixed with pixels, reads and random commands.
// ----------------------------------------------------------------------------
module page_framebuffer_glyph_plotter_test;
	timeunit 1ns;
	timeprecision 1ps;

	import pfgp_pkg::*;

	localparam int SW          = 128;
	localparam int SH          = 40;
	localparam int FB_BYTES    = SW * ((SH + 7) / 8);
	localparam int STALL_LIMIT = 5000;

	logic                  clk = 1'b0;
	logic                  arst_n;
	logic                  cfg_we;
	logic [CFG_IDX_W-1:0]  cfg_index;
	logic [CFG_DATA_W-1:0] cfg_data;

	pfgp_cmd_if cmd_ch ();
	pfgp_rsp_if rsp_ch ();

	page_framebuffer_glyph_plotter #(
		.SCREEN_WIDTH  (SW),
		.SCREEN_HEIGHT (SH)
	) dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.cmd       (cmd_ch),
		.rsp       (rsp_ch)
	);

	always begin
		#10 clk = 1'b1;
		#10 clk = 1'b0;
	end

	// image of the block
	logic [7:0]  frame_image [FB_BYTES];
	int unsigned cur_x, cur_y;
	bit          glyph_armed;
	int unsigned fw_m, fh_m;
	bit          inv_m;

	rsp_t        pending_rsp [$];
	int          err_count;
	int          items_sent;
	int          rsp_checked;
	int          reg_writes;
	int          idle_cycles;
	bit          steady;

	function automatic bit plot_image(int unsigned x, int unsigned y, bit white);
		int unsigned idx;
		logic [7:0]  m;
		if (x >= SW || y >= SH)
			return 1'b0;
		if (inv_m)
			white = !white;
		idx = x + (y / 8) * SW;
		m = 8'h01 << (y % 8);
		if (white)
			frame_image[idx] = frame_image[idx] | m;
		else
			frame_image[idx] = frame_image[idx] & ~m;
		return 1'b1;
	endfunction

	function automatic rsp_t predict_plotter_rsp(cmd_t c);
		rsp_t        r;
		int unsigned j;
		bit          fg;
		r.status = STAT_DONE;
		r.read_byte = 8'h00;
		case (op_t'(c.op))
			OP_PIXEL: begin
				if (!plot_image(32'(c.x_pos), 32'(c.y_pos), c.color))
					r.status = STAT_OUTSIDE;
			end
			OP_FILL: begin
				foreach (frame_image[i])
					frame_image[i] = c.color ? 8'hFF : 8'h00;
			end
			OP_CURSOR: begin
				cur_x = 32'(c.x_pos);
				cur_y = 32'(c.y_pos);
			end
			OP_CHAR: begin
				if (c.char_code < FIRST_PRINTABLE) begin
					glyph_armed = 1'b0;
					r.status = STAT_CTRL;
				end else if (cur_x + fw_m >= SW || cur_y + fh_m >= SH) begin
					glyph_armed = 1'b0;
					r.status = STAT_NO_ROOM;
				end else begin
					glyph_armed = 1'b1;
				end
			end
			OP_ROW: begin
				if (!glyph_armed) begin
					r.status = STAT_NO_ROOM;
				end else begin
					if (32'(c.row_index) < fh_m) begin
						for (j = 0; j < fw_m; j++) begin
							fg = (j < 16) ? c.row_bits[15 - j] : 1'b0;
							void'(plot_image(cur_x + j, cur_y + 32'(c.row_index),
								fg ? c.color : !c.color));
						end
					end else begin
						r.status = STAT_OUTSIDE;
					end
					if (c.last_row) begin
						cur_x = (cur_x + fw_m) & 32'hFF;
						glyph_armed = 1'b0;
					end
				end
			end
			OP_READ: begin
				if (32'(c.byte_address) < FB_BYTES)
					r.read_byte = frame_image[c.byte_address];
				else
					r.status = STAT_OUTSIDE;
			end
			default: ;
		endcase
		return r;
	endfunction

	// response check
	always @(posedge clk) begin
		rsp_t want;
		if (arst_n && rsp_ch.valid && rsp_ch.ready) begin
			if (pending_rsp.size() == 0) begin
				$error("response item with no expectation: status %0d read_byte %0h",
					rsp_ch.payload.status, rsp_ch.payload.read_byte);
				err_count++;
			end else begin
				want = pending_rsp.pop_front();
				rsp_checked++;
				if (rsp_ch.payload.status !== want.status) begin
					$error("status mismatch: expected %0d, actual %0d",
						want.status, rsp_ch.payload.status);
					err_count++;
				end
				if (rsp_ch.payload.read_byte !== want.read_byte) begin
					$error("read_byte mismatch: expected %0h, actual %0h",
						want.read_byte, rsp_ch.payload.read_byte);
					err_count++;
				end
			end
		end
	end

	// response side backpressure
	initial begin
		int stall;
		rsp_ch.ready <= 1'b0;
		@(posedge clk iff arst_n);
		forever begin
			stall = steady ? 0 : $urandom_range(0, 3);
			if (stall > 0) begin
				rsp_ch.ready <= 1'b0;
				repeat (stall) @(posedge clk);
			end
			rsp_ch.ready <= 1'b1;
			do @(posedge clk); while (!rsp_ch.valid);
		end
	end

	always @(posedge clk) begin
		if (!arst_n || (cmd_ch.valid && cmd_ch.ready) || (rsp_ch.valid && rsp_ch.ready)) begin
			idle_cycles <= 0;
		end else begin
			idle_cycles <= idle_cycles + 1;
			if (idle_cycles == STALL_LIMIT) begin
				$display("Some tests failed");
				$finish;
			end
		end
	end

	task automatic send_cmd(input cmd_t c);
		int gap;
		gap = steady ? 0 : $urandom_range(0, 3);
		if (gap > 0) begin
			cmd_ch.valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		cmd_ch.valid <= 1'b1;
		cmd_ch.payload <= c;
		do @(posedge clk); while (!cmd_ch.ready);
		pending_rsp.push_back(predict_plotter_rsp(c));
		items_sent++;
	endtask

	function automatic cmd_t any_cmd();
		cmd_t c;
		c.op           = 3'($urandom_range(0, 7));
		c.x_pos        = 8'($urandom_range(0, 255));
		c.y_pos        = 8'($urandom_range(0, 255));
		c.color        = 1'($urandom_range(0, 1));
		c.char_code    = 7'($urandom_range(0, 127));
		c.row_index    = 6'($urandom_range(0, 63));
		c.row_bits     = 16'($urandom_range(0, 65535));
		c.last_row     = 1'($urandom_range(0, 1));
		c.byte_address = 10'($urandom_range(0, 1023));
		return c;
	endfunction

	function automatic cmd_t op_cmd(op_t o);
		cmd_t c;
		c = any_cmd();
		c.op = o;
		return c;
	endfunction

	task automatic send_pixel(input int unsigned x, input int unsigned y, input bit col);
		cmd_t c;
		c = op_cmd(OP_PIXEL);
		c.x_pos = x[7:0];
		c.y_pos = y[7:0];
		c.color = col;
		send_cmd(c);
	endtask

	task automatic send_fill(input bit col);
		cmd_t c;
		c = op_cmd(OP_FILL);
		c.color = col;
		send_cmd(c);
	endtask

	task automatic send_cursor(input int unsigned x, input int unsigned y);
		cmd_t c;
		c = op_cmd(OP_CURSOR);
		c.x_pos = x[7:0];
		c.y_pos = y[7:0];
		send_cmd(c);
	endtask

	task automatic send_char(input int unsigned code);
		cmd_t c;
		c = op_cmd(OP_CHAR);
		c.char_code = code[6:0];
		send_cmd(c);
	endtask

	task automatic send_row(input int unsigned idx, input logic [15:0] bits, input bit col,
			input bit last);
		cmd_t c;
		c = op_cmd(OP_ROW);
		c.row_index = idx[5:0];
		c.row_bits = bits;
		c.color = col;
		c.last_row = last;
		send_cmd(c);
	endtask

	task automatic send_read(input int unsigned a);
		cmd_t c;
		c = op_cmd(OP_READ);
		c.byte_address = a[9:0];
		send_cmd(c);
	endtask

	task automatic wait_idle();
		cmd_ch.valid <= 1'b0;
		while (pending_rsp.size() != 0)
			@(posedge clk);
		repeat (10) @(posedge clk);
	endtask

	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input int unsigned val);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val[CFG_DATA_W-1:0];
		@(posedge clk);
		case (idx)
			CFG_FONT_WIDTH:  fw_m = val & 32'h1F;
			CFG_FONT_HEIGHT: fh_m = val & 32'h3F;
			CFG_INVERT:      inv_m = val[0];
			default: ;
		endcase
		reg_writes++;
	endtask

	task automatic set_font(input int unsigned w, input int unsigned h, input bit inv);
		wait_idle();
		write_reg(CFG_FONT_WIDTH, w);
		write_reg(CFG_FONT_HEIGHT, h);
		write_reg(CFG_INVERT, 32'(inv));
		cfg_we <= 1'b0;
		@(posedge clk);
	endtask

	// reset font settings assumed here
	task automatic test_directed_cases();
		send_read(0);
		send_pixel(0, 0, 1'b1);
		send_pixel(SW - 1, SH - 1, 1'b1);
		send_pixel(SW, 0, 1'b1);
		send_pixel(0, SH, 1'b1);
		send_pixel(255, 255, 1'b0);
		send_read(0);
		send_read(FB_BYTES - 1);
		send_read(FB_BYTES);
		send_read(1023);
		send_fill(1'b1);
		send_read(300);
		send_fill(1'b0);
		send_row(0, 16'hFFFF, 1'b1, 1'b1);
		send_char(31);
		send_cursor(SW - 7, 0);
		send_char(65);
		send_cursor(SW - 8, SH - 11);
		send_char(32);
		send_row(0, 16'hFFFF, 1'b1, 1'b0);
		send_row(63, 16'h0000, 1'b1, 1'b1);
		send_read(3 * SW + SW - 8);
		send_cmd(op_cmd(op_t'(3'd6)));
		send_cmd(op_cmd(op_t'(3'd7)));
		// clipped glyph after the cursor moves, then advance past 255
		send_cursor(0, 0);
		send_char(127);
		send_cursor(SW - 4, SH - 4);
		send_row(2, 16'hFE00, 1'b1, 1'b0);
		send_row(5, 16'hFFFF, 1'b1, 1'b0);
		send_cursor(252, 0);
		send_row(0, 16'hAAAA, 1'b0, 1'b1);
		send_read(4 * SW + SW - 4);
		send_char(66);
	endtask

	task automatic test_invert_and_fill();
		set_font(16, 1, 1'b1);
		send_pixel(5, 5, 1'b1);
		send_read(5);
		send_fill(1'b0);
		send_read(5);
		send_cursor(0, 0);
		send_char(90);
		send_row(0, 16'hA5A5, 1'b1, 1'b1);
		send_read(0);
		send_read(15);
		send_pixel(3, 0, 1'b0);
		send_read(3);
	endtask

	task automatic draw_char();
		int unsigned x0, y0, rows, r, k;
		bit          broken;
		cmd_t        c;
		if ($urandom_range(0, 4) != 0) begin
			x0 = (fw_m < SW) ? $urandom_range(0, SW - 1 - fw_m) : 0;
			y0 = (fh_m < SH) ? $urandom_range(0, SH - 1 - fh_m) : $urandom_range(0, 255);
			send_cursor(x0, y0);
		end
		x0 = cur_x;
		y0 = cur_y;
		send_char(($urandom_range(0, 9) == 0) ? $urandom_range(0, 31) : $urandom_range(32, 127));
		broken = ($urandom_range(0, 7) == 0);
		rows = broken ? $urandom_range(0, fh_m + 2) : fh_m;
		for (r = 0; r < rows; r++) begin
			c = op_cmd(OP_ROW);
			c.row_index = 6'((broken && $urandom_range(0, 3) == 0) ? $urandom_range(0, 63) : r);
			c.last_row = 1'(broken ? $urandom_range(0, 1) : 32'(r == rows - 1));
			send_cmd(c);
		end
		for (k = 0; k < 2; k++)
			send_read(((y0 + k * (fh_m - 1)) / 8) * SW + x0 + $urandom_range(0, fw_m - 1));
	endtask

	task automatic test_random_text();
		int unsigned fw_list [8] = '{7, 1, 16, 24, 16, 5, 3, 12};
		int unsigned fh_list [8] = '{10, 1, 40, 8, 1, 7, 39, 16};
		bit          inv_list [8] = '{0, 0, 1, 0, 1, 1, 0, 1};
		int          p, stop_at, pick;
		cmd_t        c;
		for (p = 0; p < 8; p++) begin
			set_font(fw_list[p], fh_list[p], inv_list[p]);
			stop_at = items_sent + 185;
			while (items_sent < stop_at) begin
				if ($urandom_range(0, 49) == 0)
					steady = !steady;
				pick = $urandom_range(0, 99);
				if (pick < 60) begin
					draw_char();
				end else if (pick < 75) begin
					send_pixel(($urandom_range(0, 9) != 0) ? $urandom_range(0, SW - 1)
						: $urandom_range(0, 255),
						($urandom_range(0, 9) != 0) ? $urandom_range(0, SH - 1)
						: $urandom_range(0, 255), 1'($urandom_range(0, 1)));
				end else if (pick < 90) begin
					send_read(($urandom_range(0, 9) != 0) ? $urandom_range(0, FB_BYTES - 1)
						: $urandom_range(0, 1023));
				end else begin
					c = any_cmd();
					if (c.op == OP_FILL && $urandom_range(0, 1) == 0)
						c.op = OP_READ;
					send_cmd(c);
				end
			end
			steady = 1'b0;
		end
	endtask

	initial begin
		arst_n <= 1'b0;
		cfg_we <= 1'b0;
		cfg_index <= '0;
		cfg_data <= '0;
		cmd_ch.valid <= 1'b0;
		cmd_ch.payload <= '0;
		foreach (frame_image[i])
			frame_image[i] = 8'h00;
		cur_x = 0;
		cur_y = 0;
		glyph_armed = 1'b0;
		fw_m = 32'(FONT_WIDTH_RST);
		fh_m = 32'(FONT_HEIGHT_RST);
		inv_m = 1'b0;
		steady = 1'b0;
		err_count = 0;
		items_sent = 0;
		rsp_checked = 0;
		reg_writes = 0;
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;

		test_directed_cases();
		test_invert_and_fill();
		test_random_text();
		wait_idle();

		$display("Checked %0d responses to %0d commands (directed cases, invert, text).",
			rsp_checked, items_sent);
		$display("Font and invert registers were written %0d times over 9 settings.",
			reg_writes);
		if (err_count == 0)
			$display("All tests passed");
		else
			$display("Some tests failed");
		$finish;
	end

endmodule
